@@ rtl/lcw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcw_pkg
// Types, constants and codes shared by the list cursor and window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcw_pkg;

  localparam int unsigned CNT_W       = 13;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned ROWS_W      = 8;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned MAX_ITEMS   = 4096;
  localparam int unsigned QUEUE_DEPTH = 2;

  // request kinds
  localparam logic [1:0] REQ_NAV       = 2'd0;
  localparam logic [1:0] REQ_RECONCILE = 2'd1;
  localparam logic [1:0] REQ_REMOVE    = 2'd2;
  localparam logic [1:0] REQ_TOP       = 2'd3;

  // button bits
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;

  // configuration register indexes
  localparam logic CFG_PAGE_ROWS  = 1'b0;
  localparam logic CFG_WINDOW_EXT = 1'b1;

  typedef enum logic [2:0] {
    OP_NAV_HOLD  = 3'd0,
    OP_UP        = 3'd1,
    OP_DOWN      = 3'd2,
    OP_PG_UP     = 3'd3,
    OP_PG_DOWN   = 3'd4,
    OP_RECONCILE = 3'd5,
    OP_REMOVE    = 3'd6,
    OP_TOP       = 3'd7
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [ROWS_W-1:0] page_rows;
    logic              window_ext;
  } cfg_t;

endpackage : lcw_pkg

`default_nettype wire

@@ rtl/lcw_front.sv @@
// ----------------------------------------------------------------------------
// lcw_front
// Takes requests and classifies them into commands for the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_front import lcw_pkg::*; (
  input  wire logic             start,
  input  wire logic             queue_full,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [3:0]       in_buttons,
  input  wire logic [CNT_W-1:0] in_new_count,
  input  wire logic [IDX_W-1:0] in_remove_index,
  input  wire logic [CNT_W-1:0] in_remove_count,
  output logic                  push,
  output cmd_t                  cmd
);

  assign push = start & ~queue_full;

  always_comb begin
    cmd.op    = OP_NAV_HOLD;
    cmd.count = '0;
    cmd.index = in_remove_index;
    unique case (in_req_type)
      REQ_NAV: begin
        if (in_buttons[BTN_UP]) begin
          cmd.op = OP_UP;
        end else if (in_buttons[BTN_DOWN]) begin
          cmd.op = OP_DOWN;
        end else if (in_buttons[BTN_LEFT]) begin
          cmd.op = OP_PG_UP;
        end else if (in_buttons[BTN_RIGHT]) begin
          cmd.op = OP_PG_DOWN;
        end else begin
          cmd.op = OP_NAV_HOLD;
        end
      end
      REQ_RECONCILE: begin
        cmd.op    = OP_RECONCILE;
        cmd.count = (in_new_count > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : in_new_count;
      end
      REQ_REMOVE: begin
        cmd.op    = OP_REMOVE;
        cmd.count = in_remove_count;
      end
      REQ_TOP: begin
        cmd.op = OP_TOP;
      end
      default: begin
        cmd.op = OP_NAV_HOLD;
      end
    endcase
  end

endmodule : lcw_front

`default_nettype wire

@@ rtl/lcw_queue.sv @@
// ----------------------------------------------------------------------------
// lcw_queue
// Short command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_queue import lcw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      not_empty,
  output logic      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  cmd_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign not_empty = (fill_r != '0);
  assign full      = (fill_r == CNT_QW'(DEPTH));
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule : lcw_queue

`default_nettype wire

@@ rtl/lcw_exec.sv @@
// ----------------------------------------------------------------------------
// lcw_exec
// Execution unit: holds count, cursor and window, carries out one command,
// settles the window when it is not external and issues the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_exec import lcw_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     cmd_valid,
  input  wire cmd_t                     cmd,
  output logic                          pop,
  output logic                          out_valid,
  output logic signed [CNT_W-1:0]       out_cursor,
  output logic        [IDX_W-1:0]       out_window_top,
  output logic                          out_cursor_changed,
  output logic                          out_window_changed,
  output logic                          out_any_moved
);

  localparam int unsigned SW = CNT_W + 2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETTLE = 5'b00010,
    ST_CLAMP  = 5'b00100,
    ST_REMOVE = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic        [CNT_W-1:0]  total_r, total_nxt;
  logic signed [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic        [IDX_W-1:0]  window_r, window_nxt;
  logic signed [CNT_W-1:0]  old_c_r, old_c_nxt;
  logic        [IDX_W-1:0]  old_w_r, old_w_nxt;
  logic        [IDX_W-1:0]  rm_idx_r, rm_idx_nxt;
  logic        [CNT_W-1:0]  rm_left_r, rm_left_nxt;

  logic                     ov_r, ov_nxt;
  logic signed [CNT_W-1:0]  oc_r, oc_nxt;
  logic        [IDX_W-1:0]  ow_r, ow_nxt;
  logic                     occ_r, occ_nxt;
  logic                     owc_r, owc_nxt;

  logic signed [SW-1:0] rows_s, tot_s, cur_s, win_s, top_max_s;
  logic signed [SW-1:0] c0, c, w, nt, ntop, idx_s;
  logic                 dec;

  assign out_valid          = ov_r;
  assign out_cursor         = oc_r;
  assign out_window_top     = ow_r;
  assign out_cursor_changed = occ_r;
  assign out_window_changed = owc_r;
  assign out_any_moved      = occ_r | owc_r;

  always_comb begin
    rows_s = (cfg.page_rows == '0) ? SW'(1) : $signed(SW'(cfg.page_rows));
    tot_s  = $signed(SW'(total_r));
    cur_s  = SW'(cursor_r);
    win_s  = $signed(SW'(window_r));
    idx_s  = $signed(SW'(rm_idx_r));
    top_max_s = (tot_s > rows_s) ? tot_s - rows_s : '0;
  end

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    cursor_nxt  = cursor_r;
    window_nxt  = window_r;
    old_c_nxt   = old_c_r;
    old_w_nxt   = old_w_r;
    rm_idx_nxt  = rm_idx_r;
    rm_left_nxt = rm_left_r;
    ov_nxt      = 1'b0;
    oc_nxt      = oc_r;
    ow_nxt      = ow_r;
    occ_nxt     = occ_r;
    owc_nxt     = owc_r;
    pop         = 1'b0;
    c0          = '0;
    c           = '0;
    w           = '0;
    nt          = '0;
    ntop        = '0;
    dec         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          old_c_nxt = cursor_r;
          old_w_nxt = window_r;
          case (cmd.op)
            OP_NAV_HOLD, OP_UP, OP_DOWN, OP_PG_UP, OP_PG_DOWN: begin
              if (total_r == '0) begin
                state_nxt = ST_RESULT;
              end else begin
                c0 = (cur_s < 0) ? '0 : cur_s;
                if (c0 >= tot_s) begin
                  c0 = tot_s - SW'(1);
                end
                c = c0;
                w = win_s;
                case (cmd.op)
                  OP_UP:      c = (c0 > 0) ? c0 - SW'(1) : tot_s - SW'(1);
                  OP_DOWN:    c = (c0 < tot_s - SW'(1)) ? c0 + SW'(1) : '0;
                  OP_PG_UP,
                  OP_PG_DOWN: begin
                    c = (cmd.op == OP_PG_UP) ? c0 - rows_s : c0 + rows_s;
                    w = (cmd.op == OP_PG_UP) ? win_s - rows_s : win_s + rows_s;
                    if (c >= tot_s) c = tot_s - SW'(1);
                    if (c < 0) c = '0;
                    if (w < 0) w = '0;
                    if (w > top_max_s) w = top_max_s;
                    if (!cfg.window_ext) begin
                      window_nxt = w[IDX_W-1:0];
                    end
                  end
                  default: c = c0;
                endcase
                cursor_nxt = c[CNT_W-1:0];
                state_nxt  = ST_SETTLE;
              end
            end
            OP_RECONCILE: begin
              total_nxt = cmd.count;
              if (cmd.count == '0) begin
                cursor_nxt = '1;
                if (!cfg.window_ext) begin
                  window_nxt = '0;
                end
                state_nxt = ST_RESULT;
              end else begin
                nt = $signed(SW'(cmd.count));
                c  = (cur_s >= nt) ? nt - SW'(1) : cur_s;
                if (c < 0) c = '0;
                cursor_nxt = c[CNT_W-1:0];
                state_nxt  = ST_SETTLE;
              end
            end
            OP_REMOVE: begin
              rm_idx_nxt  = cmd.index;
              rm_left_nxt = cmd.count;
              state_nxt   = ST_REMOVE;
            end
            OP_TOP: begin
              cursor_nxt = (total_r != '0) ? '0 : '1;
              if (!cfg.window_ext) begin
                window_nxt = '0;
              end
              state_nxt = ST_RESULT;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      ST_SETTLE: begin
        if (cfg.window_ext) begin
          state_nxt = ST_RESULT;
        end else begin
          if (cur_s < win_s) begin
            w = cur_s;
          end else if (cur_s >= win_s + rows_s) begin
            w = cur_s - rows_s + SW'(1);
          end else begin
            w = win_s;
          end
          if (w < 0) w = '0;
          window_nxt = w[IDX_W-1:0];
          state_nxt  = ST_CLAMP;
        end
      end

      ST_CLAMP: begin
        if (win_s > top_max_s) begin
          window_nxt = top_max_s[IDX_W-1:0];
        end
        state_nxt = ST_RESULT;
      end

      ST_REMOVE: begin
        if (rm_left_r == '0 || idx_s >= tot_s) begin
          state_nxt = ST_RESULT;
        end else begin
          rm_left_nxt = rm_left_r - CNT_W'(1);
          nt          = tot_s - SW'(1);
          total_nxt   = nt[CNT_W-1:0];
          if (nt == '0) begin
            cursor_nxt = '1;
            if (!cfg.window_ext) begin
              window_nxt = '0;
            end
          end else begin
            dec = (idx_s < cur_s);
            c   = dec ? cur_s - SW'(1) : cur_s;
            if (c >= nt) c = nt - SW'(1);
            cursor_nxt = c[CNT_W-1:0];
            if (!cfg.window_ext) begin
              ntop = (nt > rows_s) ? nt - rows_s : '0;
              w    = dec ? win_s - SW'(1) : win_s;
              if (w > ntop) w = ntop;
              if (w < 0) w = '0;
              window_nxt = w[IDX_W-1:0];
            end
          end
        end
      end

      ST_RESULT: begin
        ov_nxt    = 1'b1;
        oc_nxt    = cursor_r;
        ow_nxt    = window_r;
        occ_nxt   = (cursor_r != old_c_r);
        owc_nxt   = (window_r != old_w_r);
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= '0;
      cursor_r <= '1;
      window_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      cursor_r <= cursor_nxt;
      window_r <= window_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_c_r   <= old_c_nxt;
    old_w_r   <= old_w_nxt;
    rm_idx_r  <= rm_idx_nxt;
    rm_left_r <= rm_left_nxt;
    oc_r      <= oc_nxt;
    ow_r      <= ow_nxt;
    occ_r     <= occ_nxt;
    owc_r     <= owc_nxt;
  end

endmodule : lcw_exec

`default_nettype wire

@@ rtl/list_cursor_window_controller.sv @@
// ----------------------------------------------------------------------------
// list_cursor_window_controller
// Menu list cursor and scroll window controller.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the command queue (QUEUE_DEPTH entries) is full. Every request gives exactly
// one result, shown for a single cycle with out_valid high; the receiver
// cannot hold it off, and results come out in request order. The execution
// unit runs a navigate on a non-empty list or a reconcile to a non-zero count
// through settle and clamp while the window is owned here, through settle alone
// when it is external, and straight to result for scroll to top, navigate on
// an empty list and reconcile to zero; a remove loops in the remove state once
// per item actually removed. The queue registers each request before it runs.
// Page size and window ownership are sampled when the request is executed.
// ----------------------------------------------------------------------------
`default_nettype none

module list_cursor_window_controller import lcw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_req_type,
  input  wire logic [3:0]              in_buttons,
  input  wire logic [CNT_W-1:0]        in_new_count,
  input  wire logic [IDX_W-1:0]        in_remove_index,
  input  wire logic [CNT_W-1:0]        in_remove_count,
  output logic                         out_valid,
  output logic signed [CNT_W-1:0]      out_cursor,
  output logic        [IDX_W-1:0]      out_window_top,
  output logic                         out_cursor_changed,
  output logic                         out_window_changed,
  output logic                         out_any_moved
);

  cfg_t cfg_r, cfg_nxt;
  logic push, pop, q_full, q_not_empty;
  cmd_t push_cmd, head_cmd;

  assign busy = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_ROWS:  cfg_nxt.page_rows  = cfg_wdata[ROWS_W-1:0];
        CFG_WINDOW_EXT: cfg_nxt.window_ext = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_rows  <= ROWS_W'(8);
      cfg_r.window_ext <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcw_front u_front (
    .start           (start),
    .queue_full      (q_full),
    .in_req_type     (in_req_type),
    .in_buttons      (in_buttons),
    .in_new_count    (in_new_count),
    .in_remove_index (in_remove_index),
    .in_remove_count (in_remove_count),
    .push            (push),
    .cmd             (push_cmd)
  );

  lcw_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lcw_exec u_exec (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd_valid          (q_not_empty),
    .cmd                (head_cmd),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_cursor         (out_cursor),
    .out_window_top     (out_window_top),
    .out_cursor_changed (out_cursor_changed),
    .out_window_changed (out_window_changed),
    .out_any_moved      (out_any_moved)
  );

endmodule : list_cursor_window_controller

`default_nettype wire
